/* sv/lsm_pkg.sv */
`timescale 1ns / 1ps

package lsm_pkg;

   // field widths
   localparam int IDX_W   = 11;
   localparam int CNT_W   = 11;
   localparam int SRC_W   = 10;
   localparam int START_W = 10;
   localparam int OFS_W   = 16;
   localparam int DATA_W  = 16;
   localparam int CSR_IDX_W = 3;

   // counts above this are clamped before use
   localparam int MAX_LEDS = 1024;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEDS);

   // offset modulo chain: one cell per dividend bit, then one register for the sign fix
   localparam int CHAIN_DEPTH = OFS_W;
   localparam int SETTLE_CYCLES = CHAIN_DEPTH + 1;
   localparam int SETTLE_W = $clog2(SETTLE_CYCLES + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_REVERSED = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE_LEFT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_OFFSET    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VIRTUAL_COUNT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_COUNT     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_COUNT    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_START    = 3'd7;

   typedef struct packed {
      logic                    line_mode;
      logic                    second_reversed;
      logic                    rotate_left;
      logic signed [OFS_W-1:0] start_offset;
      logic [CNT_W-1:0]        virtual_count;
      logic [CNT_W-1:0]        first_count;
      logic [CNT_W-1:0]        second_count;
      logic [START_W-1:0]      second_start;
   } cfg_type;

   typedef struct packed {
      logic [SRC_W-1:0] base;
      logic             written;
      logic             in_second;
      logic [CNT_W-1:0] total;
   } dec_type;

   // partial remainder word handed from cell to cell
   typedef struct packed {
      logic [CNT_W-1:0] rem;
      logic [OFS_W-1:0] dvd;
      logic [CNT_W-1:0] div;
      logic             neg;
   } cell_type;

   function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
      return (c > CNT_MAX) ? CNT_MAX : c;
   endfunction

endpackage

/* sv/lsm_mod_cell.sv */
`timescale 1ns / 1ps

module lsm_mod_cell (
   input  logic              clock,
   input  lsm_pkg::cell_type prev,
   output lsm_pkg::cell_type next_ff
);
   import lsm_pkg::*;

   logic [CNT_W:0] shifted;
   logic [CNT_W:0] diff;
   cell_type       next_in;

   // one restoring division step: bring down the next dividend bit
   always_comb begin
      shifted = {prev.rem, prev.dvd[OFS_W-1]};
      diff    = shifted - {1'b0, prev.div};
      next_in.rem = (shifted >= {1'b0, prev.div}) ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      next_in.dvd = {prev.dvd[OFS_W-2:0], 1'b0};
      next_in.div = prev.div;
      next_in.neg = prev.neg;
   end

   always_ff @(posedge clock) begin
      next_ff <= next_in;
   end

endmodule

/* sv/lsm_decode.sv */
`timescale 1ns / 1ps

module lsm_decode (
   input  logic [lsm_pkg::IDX_W-1:0] led_index,
   input  lsm_pkg::cfg_type          cfg,
   output lsm_pkg::dec_type          dec
);
   import lsm_pkg::*;

   logic [CNT_W-1:0] vc;
   logic [CNT_W-1:0] fc;
   logic [CNT_W-1:0] sc;
   logic [CNT_W-1:0] p;
   logic [CNT_W-1:0] avail;
   logic [CNT_W:0]   k_w;
   logic [CNT_W-1:0] k;
   logic [CNT_W-1:0] r;
   logic [CNT_W:0]   s;
   logic             in_first;
   logic             in_sec;
   logic             in_line;

   always_comb begin
      vc = sat_count(cfg.virtual_count);
      fc = sat_count(cfg.first_count);
      sc = sat_count(cfg.second_count);
      p = (vc < fc) ? vc : fc;
      if (sc < p) begin
         p = sc;
      end
      avail = (fc < vc) ? fc : vc;

      // position inside the second segment, msb set when before it
      k_w = {1'b0, led_index} - {(CNT_W + 1 - START_W)'(0), cfg.second_start};
      k   = k_w[CNT_W-1:0];

      in_first = led_index < p;
      in_sec   = !k_w[CNT_W] && (k < p);
      in_line  = !k_w[CNT_W] && (k < sc);

      r = cfg.second_reversed ? (p - CNT_W'(1) - k) : k;
      s = cfg.second_reversed ? ({1'b0, fc} + {1'b0, sc} - (CNT_W + 1)'(1) - {1'b0, k})
                              : ({1'b0, fc} + {1'b0, k});

      dec.base      = '0;
      dec.written   = 1'b0;
      dec.in_second = 1'b0;
      if (!cfg.line_mode) begin
         dec.total = p;
         // both segments write in one pass, so on overlap the second only wins when it starts at zero
         if (in_sec && (!in_first || (cfg.second_start == '0))) begin
            dec.base      = r[SRC_W-1:0];
            dec.written   = 1'b1;
            dec.in_second = 1'b1;
         end else if (in_first) begin
            dec.base    = led_index[SRC_W-1:0];
            dec.written = 1'b1;
         end
      end else begin
         dec.total = vc;
         if (in_line && (s < {1'b0, vc})) begin
            dec.base      = s[SRC_W-1:0];
            dec.written   = 1'b1;
            dec.in_second = 1'b1;
         end else if (led_index < avail) begin
            // skipped second source falls back to the first segment
            dec.base    = led_index[SRC_W-1:0];
            dec.written = 1'b1;
         end
      end
   end

endmodule

/* sv/led_segment_source_mapper_unit.sv */
`timescale 1ns / 1ps

// LED segment source mapper.
// req_ channel: one physical led index per word; rsp_ channel: the virtual
// buffer entry that LED shows, whether it is written and whether the second
// segment supplied it. Both channels use valid/ready.
// A result passes the decode register and then the output register before rsp_valid;
// a new word is taken every cycle unless a stall or the settling row holds req_ready
// low. An output register and a decode register part the two sides, so a stalled
// rsp_ready holds one result while one more word may still enter. The start offset
// modulo the active length comes from a row of 16 division cells plus one fix-up
// register, fed every cycle from the csr registers. After reset and after every csr
// write req_ready stays low while that row settles; csr words are taken at any time through csr_we.
// Reset (synchronous, active high) loads the register reset values and
// empties the pipeline.

module led_segment_source_mapper_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lsm_pkg::IDX_W-1:0]         req_led_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lsm_pkg::SRC_W-1:0]         rsp_source_index,
   output logic                              rsp_written,
   output logic                              rsp_in_second,
   input  logic                              csr_we,
   input  logic [lsm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lsm_pkg::DATA_W-1:0]        csr_wdata
);
   import lsm_pkg::*;

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   logic [SETTLE_W-1:0] settle_ff;
   logic [SETTLE_W-1:0] settle_in;

   dec_type             dec;
   dec_type             b_dec_ff;
   logic                b_valid_ff;
   logic                b_valid_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [SRC_W-1:0]    rsp_src_ff;
   logic [SRC_W-1:0]    rsp_src_in;
   logic                rsp_wr_ff;
   logic                rsp_sec_ff;

   cell_type            chain [CHAIN_DEPTH+1];
   logic [SRC_W-1:0]    off_ff;
   logic [SRC_W-1:0]    off_in;
   logic [CNT_W-1:0]    tail_diff;

   logic                out_go;
   logic                b_go;
   logic                accept;
   logic signed [CNT_W+1:0] adj;
   logic signed [CNT_W+1:0] tot_s;
   logic signed [CNT_W+1:0] wrap;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LINE_MODE:       cfg_in.line_mode       = csr_wdata[0];
            CSR_SECOND_REVERSED: cfg_in.second_reversed = csr_wdata[0];
            CSR_ROTATE_LEFT:     cfg_in.rotate_left     = csr_wdata[0];
            CSR_START_OFFSET:    cfg_in.start_offset    = $signed(csr_wdata[OFS_W-1:0]);
            CSR_VIRTUAL_COUNT:   cfg_in.virtual_count   = csr_wdata[CNT_W-1:0];
            CSR_FIRST_COUNT:     cfg_in.first_count     = csr_wdata[CNT_W-1:0];
            CSR_SECOND_COUNT:    cfg_in.second_count    = csr_wdata[CNT_W-1:0];
            CSR_SECOND_START:    cfg_in.second_start    = csr_wdata[START_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
      if (csr_we) begin
         settle_in = SETTLE_W'(SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - SETTLE_W'(1);
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_mode       <= 1'b0;
         cfg_ff.second_reversed <= 1'b1;
         cfg_ff.rotate_left     <= 1'b0;
         cfg_ff.start_offset    <= '0;
         cfg_ff.virtual_count   <= '0;
         cfg_ff.first_count     <= '0;
         cfg_ff.second_count    <= '0;
         cfg_ff.second_start    <= '0;
         settle_ff              <= SETTLE_W'(SETTLE_CYCLES);
      end else begin
         cfg_ff    <= cfg_in;
         settle_ff <= settle_in;
      end
   end

   // per-word decode of segment membership and unrotated source
   lsm_decode u_decode (
      .led_index (req_led_index),
      .cfg       (cfg_ff),
      .dec       (dec)
   );

   // offset modulo active length: magnitude through the cells, sign fixed at the tail
   always_comb begin
      chain[0].rem = '0;
      chain[0].dvd = cfg_ff.start_offset[OFS_W-1] ? OFS_W'(-cfg_ff.start_offset)
                                                  : OFS_W'(cfg_ff.start_offset);
      chain[0].div = dec.total;
      chain[0].neg = cfg_ff.start_offset[OFS_W-1];
   end

   for (genvar g = 0; g < CHAIN_DEPTH; g++) begin : g_cell
      lsm_mod_cell u_cell (
         .clock   (clock),
         .prev    (chain[g]),
         .next_ff (chain[g+1])
      );
   end

   always_comb begin
      tail_diff = chain[CHAIN_DEPTH].div - chain[CHAIN_DEPTH].rem;
      off_in = (chain[CHAIN_DEPTH].neg && (chain[CHAIN_DEPTH].rem != '0))
               ? tail_diff[SRC_W-1:0] : chain[CHAIN_DEPTH].rem[SRC_W-1:0];
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in;
   end

   // pipeline flow
   assign out_go    = !rsp_valid_ff || rsp_ready;
   assign b_go      = !b_valid_ff || out_go;
   assign req_ready = b_go && (settle_ff == '0);
   assign accept    = req_valid && req_ready;

   always_comb begin
      b_valid_in   = b_go ? accept : b_valid_ff;
      rsp_valid_in = out_go ? b_valid_ff : rsp_valid_ff;

      // rotate and wrap once into [0, total)
      tot_s = $signed({2'b00, b_dec_ff.total});
      adj = cfg_ff.rotate_left
            ? $signed({3'b000, off_ff}) - $signed({3'b000, b_dec_ff.base})
            : $signed({3'b000, off_ff}) + $signed({3'b000, b_dec_ff.base});
      if (adj < 0) begin
         wrap = adj + tot_s;
      end else if (adj >= tot_s) begin
         wrap = adj - tot_s;
      end else begin
         wrap = adj;
      end
      rsp_src_in = b_dec_ff.written ? wrap[SRC_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_go) begin
         b_dec_ff <= dec;
      end
      if (out_go) begin
         rsp_src_ff <= rsp_src_in;
         rsp_wr_ff  <= b_dec_ff.written;
         rsp_sec_ff <= b_dec_ff.in_second;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_source_index = rsp_src_ff;
   assign rsp_written      = rsp_wr_ff;
   assign rsp_in_second    = rsp_sec_ff;

   // no word enters while the offset row settles after a csr write
   assert property (@(posedge clock) disable iff (reset)
      $past(csr_we) |-> !req_ready)
      else $error("word accepted right after a csr write");

   // unwritten results carry no source and no segment
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_wr_ff) |-> ((rsp_src_ff == '0) && !rsp_sec_ff))
      else $error("unwritten result carries a source");

   // written sources stay below the active length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_wr_ff) |-> ({1'b0, rsp_src_ff} < dec.total))
      else $error("source index outside active length");

   // a held result is not overwritten while stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_src_ff)))
      else $error("stalled result lost");

endmodule

/* bench/led_map_checker.sv */
`timescale 1ns / 1ps

module led_map_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [lsm_pkg::IDX_W-1:0]     req_led_index,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [lsm_pkg::SRC_W-1:0]     rsp_source_index,
   input  logic                          rsp_written,
   input  logic                          rsp_in_second,
   input  logic                          csr_we,
   input  logic [lsm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lsm_pkg::DATA_W-1:0]    csr_wdata,
   output int                            failures,
   output int                            pending
);
   import lsm_pkg::*;

   typedef struct packed {
      logic [SRC_W-1:0] source_index;
      logic             written;
      logic             in_second;
   } led_map_type;

   led_map_type awaited_maps[$];

   // shadow of the register file
   logic mode_line   = 1'b0;
   logic rev_second  = 1'b1;
   logic rot_left    = 1'b0;
   int   ofs         = 0;
   int   virt_cnt    = 0;
   int   first_cnt   = 0;
   int   second_cnt  = 0;
   int   second_base = 0;

   function automatic int clamp_count(input int c);
      return (c > MAX_LEDS) ? MAX_LEDS : c;
   endfunction

   // rotate by the start offset, both steps taken non-negative modulo total
   function automatic int wrap_source(input int base, input int total);
      int r;
      int w;
      if (total <= 0)
         return 0;
      r = ofs % total;
      if (r < 0)
         r += total;
      w = rot_left ? r - base : r + base;
      w = w % total;
      if (w < 0)
         w += total;
      return w;
   endfunction

   function automatic led_map_type resolve_led(input logic [IDX_W-1:0] led);
      int j, k, vc, fc, sc, p, s, avail;
      bit hit_first, hit_second;
      led_map_type m;
      j  = int'(led);
      vc = clamp_count(virt_cnt);
      fc = clamp_count(first_cnt);
      sc = clamp_count(second_cnt);
      k  = j - second_base;
      m  = '0;
      if (!mode_line) begin
         p = vc;
         if (p > fc) p = fc;
         if (p > sc) p = sc;
         hit_first  = j < p;
         hit_second = (k >= 0) && (k < p);
         // both segments write per step, first then second
         if (hit_second && (!hit_first || second_base == 0)) begin
            m.source_index = SRC_W'(wrap_source(rev_second ? p - 1 - k : k, p));
            m.written      = 1'b1;
            m.in_second    = 1'b1;
         end else if (hit_first) begin
            m.source_index = SRC_W'(wrap_source(j, p));
            m.written      = 1'b1;
         end
      end else begin
         avail = (fc < vc) ? fc : vc;
         if (k >= 0 && k < sc) begin
            s = rev_second ? fc + (sc - 1 - k) : fc + k;
            if (s < vc) begin
               m.source_index = SRC_W'(wrap_source(s, vc));
               m.written      = 1'b1;
               m.in_second    = 1'b1;
            end
         end
         // skipped second source falls back to the first segment
         if (!m.written && j < avail) begin
            m.source_index = SRC_W'(wrap_source(j, vc));
            m.written      = 1'b1;
         end
      end
      return m;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      led_map_type want;
      if (reset) begin
         mode_line   = 1'b0;
         rev_second  = 1'b1;
         rot_left    = 1'b0;
         ofs         = 0;
         virt_cnt    = 0;
         first_cnt   = 0;
         second_cnt  = 0;
         second_base = 0;
         awaited_maps.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LINE_MODE:       mode_line   = csr_wdata[0];
               CSR_SECOND_REVERSED: rev_second  = csr_wdata[0];
               CSR_ROTATE_LEFT:     rot_left    = csr_wdata[0];
               CSR_START_OFFSET:    ofs         = int'($signed(csr_wdata[OFS_W-1:0]));
               CSR_VIRTUAL_COUNT:   virt_cnt    = int'(csr_wdata[CNT_W-1:0]);
               CSR_FIRST_COUNT:     first_cnt   = int'(csr_wdata[CNT_W-1:0]);
               CSR_SECOND_COUNT:    second_cnt  = int'(csr_wdata[CNT_W-1:0]);
               CSR_SECOND_START:    second_base = int'(csr_wdata[START_W-1:0]);
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            awaited_maps.push_back(resolve_led(req_led_index));
         if (rsp_valid && rsp_ready) begin
            if (awaited_maps.size() == 0) begin
               failures++;
               $display("%0t: unexpected word, expected none, %s %0d written %0b second %0b",
                        $time, "actual source", rsp_source_index, rsp_written,
                        rsp_in_second);
            end else begin
               want = awaited_maps.pop_front();
               check_field("source_index", int'(want.source_index), int'(rsp_source_index));
               check_field("written", int'(want.written), int'(rsp_written));
               check_field("in_second", int'(want.in_second), int'(rsp_in_second));
            end
         end
      end
      pending = awaited_maps.size();
   end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import lsm_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int PHASES = 12;

   typedef struct {
      bit               line;
      bit               rev;
      bit               rotl;
      logic [OFS_W-1:0] ofs;
      logic [CNT_W-1:0] vc;
      logic [CNT_W-1:0] fc;
      logic [CNT_W-1:0] sc;
      logic [START_W-1:0] ss;
   } strip_setup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [IDX_W-1:0] req_led_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [SRC_W-1:0] rsp_source_index;
   logic rsp_written;
   logic rsp_in_second;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_wdata = '0;

   int failures;
   int pending;
   int req_idle_pct = 15;
   int rsp_idle_pct = 67;
   int words_sent = 0;
   int quiet = 0;
   int hold_left = 0;
   bit pressure_done = 1'b0;
   strip_setup_type cur;

   led_segment_source_mapper_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_led_index(req_led_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_source_index(rsp_source_index),
      .rsp_written(rsp_written), .rsp_in_second(rsp_in_second),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   led_map_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_led_index(req_led_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_source_index(rsp_source_index),
      .rsp_written(rsp_written), .rsp_in_second(rsp_in_second),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .pending(pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // receiver; one long hold-off once the stream runs without gaps
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!pressure_done && words_sent >= 1100) begin
         pressure_done <= 1'b1;
         hold_left <= 80;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic strip_setup_type make_setup(input bit line, input bit rev, input bit rotl,
                                                  input int ofs, input int vc, input int fc,
                                                  input int sc, input int ss);
      strip_setup_type s;
      s.line = line;
      s.rev  = rev;
      s.rotl = rotl;
      s.ofs  = OFS_W'(ofs);
      s.vc   = CNT_W'(vc);
      s.fc   = CNT_W'(fc);
      s.sc   = CNT_W'(sc);
      s.ss   = START_W'(ss);
      return s;
   endfunction

   function automatic logic [CNT_W-1:0] pick_count(input bit extreme);
      logic [CNT_W-1:0] c;
      if (extreme) begin
         case ($urandom_range(0, 4))
            0:       c = '0;
            1:       c = CNT_W'(1);
            2:       c = CNT_W'(1023);
            3:       c = CNT_MAX;
            default: c = CNT_W'($urandom_range(1025, 2047));
         endcase
      end else if ($urandom_range(0, 9) == 0) begin
         c = CNT_W'($urandom_range(0, 2047));
      end else begin
         c = CNT_W'($urandom_range(0, 40));
      end
      return c;
   endfunction

   function automatic strip_setup_type random_setup(input bit line, input bit extreme);
      strip_setup_type s;
      s.line = line;
      s.rev  = 1'($urandom_range(0, 1));
      s.rotl = 1'($urandom_range(0, 1));
      s.vc   = pick_count(extreme);
      s.fc   = pick_count(extreme);
      s.sc   = pick_count(extreme);
      if (extreme) begin
         case ($urandom_range(0, 3))
            0:       s.ofs = 16'h8000;
            1:       s.ofs = 16'h7fff;
            2:       s.ofs = 16'hffff;
            default: s.ofs = '0;
         endcase
         s.ss = ($urandom_range(0, 1) == 1) ? START_W'(1023) : START_W'($urandom_range(0, 1023));
      end else begin
         s.ofs = ($urandom_range(0, 1) == 1) ? OFS_W'($urandom) : OFS_W'($urandom_range(0, 40) - 20);
         s.ss  = ($urandom_range(0, 3) == 0) ? '0 : START_W'($urandom_range(0, 40));
      end
      return s;
   endfunction

   // mostly near the segments, a quarter anywhere on the strip
   function automatic logic [IDX_W-1:0] pick_led();
      int fc, sc, reach;
      fc = (cur.fc > CNT_MAX) ? MAX_LEDS : int'(cur.fc);
      sc = (cur.sc > CNT_MAX) ? MAX_LEDS : int'(cur.sc);
      reach = ((fc > int'(cur.ss) + sc) ? fc : int'(cur.ss) + sc) + 3;
      if (reach > 2047)
         reach = 2047;
      if ($urandom_range(0, 3) == 0)
         return IDX_W'($urandom_range(0, 2047));
      return IDX_W'($urandom_range(0, reach));
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // unused upper bits carry noise
   task automatic apply_setup(input strip_setup_type s);
      cur = s;
      write_reg(CSR_LINE_MODE, {15'($urandom), s.line});
      write_reg(CSR_SECOND_REVERSED, {15'($urandom), s.rev});
      write_reg(CSR_ROTATE_LEFT, {15'($urandom), s.rotl});
      write_reg(CSR_START_OFFSET, s.ofs);
      write_reg(CSR_VIRTUAL_COUNT, {5'($urandom), s.vc});
      write_reg(CSR_FIRST_COUNT, {5'($urandom), s.fc});
      write_reg(CSR_SECOND_COUNT, {5'($urandom), s.sc});
      write_reg(CSR_SECOND_START, {6'($urandom), s.ss});
      csr_we <= 1'b0;
   endtask

   task automatic send_word(input logic [IDX_W-1:0] idx);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_led_index <= idx;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   task automatic run_probe(input strip_setup_type s, input int leds[]);
      drain();
      apply_setup(s);
      foreach (leds[i])
         send_word(IDX_W'(leds[i]));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // mirror overlap away from zero, reversed second, negative offset
      run_probe(make_setup(1'b0, 1'b1, 1'b0, -3, 10, 10, 10, 4),
                '{0, 3, 4, 9, 10, 13, 14, 2047});
      // mirror with second segment at zero, lowest offset, left rotation
      run_probe(make_setup(1'b0, 1'b0, 1'b1, -32768, 6, 9, 7, 0), '{0, 5, 6});
      // line reversed where the first second sources fall past the buffer
      run_probe(make_setup(1'b1, 1'b1, 1'b0, 5, 12, 5, 10, 3), '{2, 3, 5, 6, 12, 13});
      // saturated counts, top offset, last start
      run_probe(make_setup(1'b1, 1'b0, 1'b1, 32767, 2047, 2047, 2047, 1023),
                '{0, 1022, 1023, 2046, 2047});
      // empty virtual buffer
      run_probe(make_setup(1'b0, 1'b1, 1'b0, 0, 0, 8, 8, 2), '{0, 1});

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         apply_setup(random_setup(ph[0], ph % 4 == 0));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph * ITEMS_PER_PHASE + n < 500) begin
               req_idle_pct = 15;
               rsp_idle_pct = 67;
            end else if (ph * ITEMS_PER_PHASE + n < 1000) begin
               req_idle_pct = 67;
               rsp_idle_pct = 15;
            end else begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
            send_word(pick_led());
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
